/* rtl/mcfb_pkg.sv */
package mcfb_pkg;

  // default table size, one entry per motor
  localparam int unsigned NUM_MOTORS_DEF = 24;

  // item kinds carried on the input tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // frame delimiters
  localparam logic [7:0] CHAR_S = 8'h53;
  localparam logic [7:0] CHAR_E = 8'h45;

  // channel thresholds
  localparam logic [11:0] PAIR_ARM_LVL  = 12'd1800;
  localparam logic [11:0] PAIR_FIRE_LVL = 12'd1500;
  localparam logic [11:0] MODE_TEST_LVL = 12'd1200;
  localparam logic [11:0] MODE_NORM_LVL = 12'd1800;
  localparam logic [11:0] SEL_NEUT_LO   = 12'd1200;
  localparam logic [11:0] SEL_NEUT_HI   = 12'd1800;
  localparam logic [11:0] SEL_RESET_VAL = 12'd1000;
  localparam logic [12:0] SEL_STEP      = 13'd300;
  localparam logic [15:0] THR_OFFSET    = 16'd990;

  // checksum modulus
  localparam logic [8:0] CKS_MOD = 9'd255;

  // load index widened so it compares against table sizes up to 127
  localparam int unsigned IDX_EXT_W = 7;

  // control of the shared checksum unit
  typedef struct packed {
    logic       init;
    logic [7:0] init_val;
    logic       add;
    logic [7:0] addend;
  } acc_ctrl_t;

endpackage

/* rtl/mcfb_ram.sv */
module mcfb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 24,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/mcfb_mod_acc.sv */
module mcfb_mod_acc (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mcfb_pkg::acc_ctrl_t ctrl_i,
  output logic [7:0]          acc_o
);

  import mcfb_pkg::*;

  logic [7:0] acc_q, acc_d;
  logic [8:0] sum;
  logic [8:0] red;

  // acc stays below 255, so one conditional subtract keeps it reduced
  always_comb begin
    sum = {1'b0, acc_q} + {1'b0, ctrl_i.addend};
    red = (sum >= CKS_MOD) ? (sum - CKS_MOD) : sum;
    acc_d = acc_q;
    if (ctrl_i.init) begin
      acc_d = ctrl_i.init_val;
    end else if (ctrl_i.add) begin
      acc_d = red[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

/* rtl/motor_command_frame_builder_core.sv */
// motor command frame builder
// input stream (s_axis): one item per load or control tick; tuser selects the kind
//   load item : stores power_value at power_index in the power table if in range, no output
//   tick item : checks pairing, then the mode channel, and emits zero to NUM_MOTORS+3 items
// output stream (m_axis): one frame byte per item, tlast on the final item of a tick,
//   tuser flags a pairing request or a heading reset
// frame sequence
//   a tick is accepted, then emits one item per cycle while the sink is ready:
//   'S', NUM_MOTORS data bytes, checksum, 'E' = NUM_MOTORS + 3 items (27 by default)
//   the bytes come from the byte sequencer, which reads the power table through one
//   ram read port and folds each data byte into a single mod-255 accumulator
//   a pairing tick emits one item; an idle-mode tick emits nothing
//   s_axis_tready_o is low from the accept of an emitting tick until its last item is registered
// stall: a held-off output item sits in the output register and the sequencer waits
// reset: the power table reads as all zeros (per-entry valid bits), the motor index,
//   arming flags and the output valid clear, the last select value becomes 1000
module motor_command_frame_builder_core #(
  parameter int unsigned NUM_MOTORS = mcfb_pkg::NUM_MOTORS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // s_axis tdata, lowest bit up: power_index[4:0], power_value[12:5], throttle_rc[24:13],
  //   select_rc[36:25], mode_rc[48:37], pairing_rc[60:49], zero fill[63:61]
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,
  // s_axis tuser: cmd[0]
  input  logic [0:0]  s_axis_tuser_i,
  // m_axis tdata: tx_byte[7:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  // m_axis tuser, lowest bit up: pairing_request[0], heading_reset[1]
  output logic [1:0]  m_axis_tuser_o
);

  import mcfb_pkg::*;

  localparam int unsigned AW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_MOTORS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAIR,
    ST_HEAD,
    ST_DATA,
    ST_SUM,
    ST_END
  } state_e;

  // input fields
  logic [4:0]  power_index;
  logic [7:0]  power_value;
  logic [11:0] throttle_rc;
  logic [11:0] select_rc;
  logic [11:0] mode_rc;
  logic [11:0] pairing_rc;
  logic        cmd;

  assign power_index = s_axis_tdata_i[4:0];
  assign power_value = s_axis_tdata_i[12:5];
  assign throttle_rc = s_axis_tdata_i[24:13];
  assign select_rc   = s_axis_tdata_i[36:25];
  assign mode_rc     = s_axis_tdata_i[48:37];
  assign pairing_rc  = s_axis_tdata_i[60:49];
  assign cmd         = s_axis_tuser_i[0];

  state_e         state_q;
  logic [AW-1:0]  idx_q;
  logic           test_q;
  logic [13:0]    thr_q;
  logic           head_q;
  logic [11:0]    last_sel_q;
  logic [AW-1:0]  motor_q;
  logic           head_armed_q;
  logic           pair_armed_q;
  logic           out_valid_q;
  logic [7:0]     out_byte_q;
  logic           out_last_q;
  logic           out_pair_q;
  logic           out_head_q;
  logic [NUM_MOTORS-1:0] vld_q;
  logic           vld_rd_q;

  logic           in_acc;
  logic           slot_free;
  logic           out_load;
  logic [15:0]    thr_full;
  logic [13:0]    thr;
  logic signed [12:0] sel_diff;
  logic           sel_neutral;
  logic           step_dn;
  logic           step_up;
  logic [AW-1:0]  motor_nxt;
  logic           mode_test;
  logic           mode_idle;
  logic           pair_fire;
  logic [IDX_EXT_W-1:0] idx_ext;
  logic           ram_we;
  logic           ram_re;
  logic [AW-1:0]  ram_raddr;
  logic [7:0]     ram_rdata;
  logic [7:0]     data_byte;
  logic [7:0]     cks;
  acc_ctrl_t      acc_ctrl;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free       = !out_valid_q || m_axis_tready_i;
  // an emitting state loads the output register whenever the slot frees up
  assign out_load        = slot_free &&
                           (state_q inside {ST_PAIR, ST_HEAD, ST_DATA, ST_SUM, ST_END});

  // throttle wraps in 16 bits before the divide by four
  assign thr_full = {4'b0000, throttle_rc} - THR_OFFSET;
  assign thr      = thr_full[15:2];

  // select channel stepping
  assign sel_diff    = $signed({1'b0, select_rc}) - $signed({1'b0, last_sel_q});
  assign sel_neutral = (select_rc > SEL_NEUT_LO) && (select_rc < SEL_NEUT_HI);
  assign step_dn     = sel_diff < -$signed(SEL_STEP);
  assign step_up     = sel_diff > $signed(SEL_STEP);

  always_comb begin
    motor_nxt = motor_q;
    if (step_dn && !sel_neutral) begin
      motor_nxt = (motor_q == '0) ? LAST_IDX : motor_q - AW'(1);
    end else if (step_up && !sel_neutral) begin
      motor_nxt = (motor_q == LAST_IDX) ? '0 : motor_q + AW'(1);
    end
  end

  assign mode_test = mode_rc < MODE_TEST_LVL;
  assign mode_idle = !mode_test && (mode_rc < MODE_NORM_LVL);
  assign pair_fire = pair_armed_q && (pairing_rc < PAIR_FIRE_LVL);

  // table write on load items within range
  assign idx_ext = IDX_EXT_W'(power_index);
  assign ram_we  = in_acc && (cmd == CMD_LOAD) && (idx_ext < IDX_EXT_W'(NUM_MOTORS));

  // reads run one byte ahead of emission: entry 0 with 'S', entry i+1 with byte i
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (state_q == ST_HEAD) begin
      ram_re = slot_free;
    end else if (state_q == ST_DATA) begin
      ram_re    = slot_free && (idx_q != LAST_IDX);
      ram_raddr = idx_q + AW'(1);
    end
  end

  always_comb begin
    if (test_q) begin
      data_byte = (idx_q == motor_q) ? thr_q[7:0] : 8'h00;
    end else begin
      data_byte = vld_rd_q ? ram_rdata : 8'h00;
    end
  end

  // test checksum starts at the throttle high part: thr mod 255 = hi + lo mod 255
  always_comb begin
    acc_ctrl.init     = in_acc;
    acc_ctrl.init_val = mode_test ? {2'b00, thr[13:8]} : 8'h00;
    acc_ctrl.add      = (state_q == ST_DATA) && slot_free;
    acc_ctrl.addend   = data_byte;
  end

  mcfb_ram #(
    .WIDTH (8),
    .DEPTH (NUM_MOTORS),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_ext[AW-1:0]),
    .wdata_i (power_value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mcfb_mod_acc u_cks (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (acc_ctrl),
    .acc_o  (cks)
  );

  // valid bits make the table read as zero until an entry is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ram_we) begin
      vld_q[idx_ext[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      vld_rd_q <= vld_q[ram_raddr];
    end
  end

  // sequencer with the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      test_q       <= 1'b0;
      head_q       <= 1'b0;
      last_sel_q   <= SEL_RESET_VAL;
      motor_q      <= '0;
      head_armed_q <= 1'b0;
      pair_armed_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc && (cmd == CMD_TICK)) begin
            if (pair_fire) begin
              pair_armed_q <= 1'b0;
              state_q      <= ST_PAIR;
            end else begin
              pair_armed_q <= pair_armed_q || (pairing_rc > PAIR_ARM_LVL);
              if (mode_idle) begin
                head_armed_q <= 1'b1;
              end else if (mode_test) begin
                head_armed_q <= 1'b1;
                head_q       <= 1'b0;
                test_q       <= 1'b1;
                thr_q        <= thr;
                motor_q      <= motor_nxt;
                if (step_dn || step_up) begin
                  last_sel_q <= select_rc;
                end
                state_q <= ST_HEAD;
              end else begin
                head_armed_q <= 1'b0;
                head_q       <= head_armed_q;
                test_q       <= 1'b0;
                state_q      <= ST_HEAD;
              end
            end
          end
        end
        ST_PAIR: begin
          if (slot_free) begin
            out_byte_q  <= 8'h00;
            out_last_q  <= 1'b1;
            out_pair_q  <= 1'b1;
            out_head_q  <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        ST_HEAD: begin
          if (slot_free) begin
            out_byte_q  <= CHAR_S;
            out_last_q  <= 1'b0;
            out_pair_q  <= 1'b0;
            out_head_q  <= head_q;
            idx_q       <= '0;
            state_q     <= ST_DATA;
          end
        end
        ST_DATA: begin
          if (slot_free) begin
            out_byte_q  <= data_byte;
            out_last_q  <= 1'b0;
            out_pair_q  <= 1'b0;
            out_head_q  <= 1'b0;
            if (idx_q == LAST_IDX) begin
              state_q <= ST_SUM;
            end else begin
              idx_q <= idx_q + AW'(1);
            end
          end
        end
        ST_SUM: begin
          if (slot_free) begin
            out_byte_q  <= cks;
            out_last_q  <= 1'b0;
            out_pair_q  <= 1'b0;
            out_head_q  <= 1'b0;
            state_q     <= ST_END;
          end
        end
        ST_END: begin
          if (slot_free) begin
            out_byte_q  <= CHAR_E;
            out_last_q  <= 1'b1;
            out_pair_q  <= 1'b0;
            out_head_q  <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = {out_head_q, out_pair_q};

endmodule

/* rtl/mcfb_checker.sv */
module mcfb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic        m_axis_tlast_o,
  input logic [1:0]  m_axis_tuser_o
);

  import mcfb_pkg::*;

  // a stalled output item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)
       && $stable(m_axis_tuser_o)))
    else $error("output item changed while stalled");

  // pairing result is a lone zero item closing the tick
  a_pair_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |->
      (m_axis_tlast_o && (m_axis_tdata_o == 8'h00) && !m_axis_tuser_o[1]))
    else $error("malformed pairing item");

  // heading reset rides only on a frame start
  a_head_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |->
      ((m_axis_tdata_o == CHAR_S) && !m_axis_tlast_o))
    else $error("heading reset off a frame start");

  // a tick in progress keeps the input closed while a non-last item is on the output
  a_busy_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o) |-> !s_axis_tready_o)
    else $error("input open during a frame");

endmodule

bind motor_command_frame_builder_core mcfb_checker u_mcfb_checker (.*);
